[rtl/mssu_pkg.sv]
// Shared types and constants for the maximin spawn point select unit.
// No dependencies; imported by the distance unit, the compare stages and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mssu_pkg;

  // Fixed port widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 21;
  localparam int IDX_W  = 4;
  localparam int DIST_W = 46;

  // Command codes carried by the input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD_CAND = 2'd1,
    CMD_ADD_OCC  = 2'd2,
    CMD_SELECT   = 2'd3
  } cmd_t;

  // Axis served by the shared squarer in a given cycle
  typedef enum logic [1:0] {
    PH_X = 2'd0,
    PH_Y = 2'd1,
    PH_Z = 2'd2
  } ph_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PRIME = 3'd1,
    ST_RUN   = 3'd2,
    ST_DRAIN = 3'd3,
    ST_OUT   = 3'd4
  } state_t;

  // Travels with each pair through the distance and compare pipeline
  typedef struct packed {
    logic             occ_first;
    logic             occ_last;
    logic             cand_last;
    logic [IDX_W-1:0] cand_idx;
  } pair_tag_t;

endpackage

`default_nettype wire

[rtl/mssu_point_ram.sv]
// Point store: one write port, one read port with registered read data.
// Depends on nothing; instantiated twice by the top level.
`timescale 1ns / 1ps
`default_nettype none

module mssu_point_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int WIDTH  = 63
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/mssu_dist_unit.sv]
// Squared distance unit: one shared squarer, one axis per cycle, then accumulate.
// Depends on mssu_pkg (ph_t, pair_tag_t).
`timescale 1ns / 1ps
`default_nettype none

module mssu_dist_unit #(
  parameter int COORD_BITS = 21
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  mssu_pkg::ph_t               ph,
  input  logic [3*COORD_BITS-1:0]     cand_pt,
  input  logic [3*COORD_BITS-1:0]     occ_pt,
  input  mssu_pkg::pair_tag_t         tag_in,
  output logic                        dist_valid,
  output logic [2*COORD_BITS+1:0]     dist_sq,
  output mssu_pkg::pair_tag_t         tag_out
);
  import mssu_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS;
  localparam int DSW = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] a;
  logic signed [COORD_BITS-1:0] b;
  logic signed [DW-1:0]         diff;
  logic signed [2*DW-1:0]       prod;
  logic [SQW-1:0]               sq;
  logic                         sq_valid;
  ph_t                          sq_ph;
  pair_tag_t                    sq_tag;
  logic [DSW-1:0]               acc;
  logic [DSW-1:0]               acc_sum;

  // pick the axis for this cycle
  always_comb begin
    case (ph)
      PH_X: begin
        a = cand_pt[COORD_BITS-1:0];
        b = occ_pt[COORD_BITS-1:0];
      end
      PH_Y: begin
        a = cand_pt[2*COORD_BITS-1:COORD_BITS];
        b = occ_pt[2*COORD_BITS-1:COORD_BITS];
      end
      default: begin
        a = cand_pt[3*COORD_BITS-1:2*COORD_BITS];
        b = occ_pt[3*COORD_BITS-1:2*COORD_BITS];
      end
    endcase
  end

  // difference is exact in one extra bit; square is non-negative
  assign diff = DW'(a) - DW'(b);
  assign prod = diff * diff;

  // squarer output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= issue;
    end
    sq     <= prod[SQW-1:0];
    sq_ph  <= ph;
    sq_tag <= tag_in;
  end

  assign acc_sum = acc + DSW'(sq);

  // accumulate the three axes; the sum leaves on the Z term
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else begin
      dist_valid <= sq_valid && (sq_ph == PH_Z);
    end
    if (sq_valid) begin
      case (sq_ph)
        PH_X:    acc     <= DSW'(sq);
        PH_Y:    acc     <= acc_sum;
        default: dist_sq <= acc_sum;
      endcase
    end
    tag_out <= sq_tag;
  end

endmodule

`default_nettype wire

[rtl/mssu_maximin.sv]
// Maximin compare stages: running minimum per candidate, then running maximum.
// Depends on mssu_pkg (pair_tag_t, IDX_W).
`timescale 1ns / 1ps
`default_nettype none

module mssu_maximin #(
  parameter int DSW = 44
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           dist_valid,
  input  logic [DSW-1:0]                 dist_sq,
  input  mssu_pkg::pair_tag_t            tag,
  output logic                           found,
  output logic [mssu_pkg::IDX_W-1:0]     best_idx,
  output logic [DSW-1:0]                 best,
  output logic                           done
);
  import mssu_pkg::*;

  logic [DSW-1:0] mn;
  logic [DSW-1:0] mn_new;
  logic           mn_valid;
  pair_tag_t      mn_tag;

  // minimum over the occupied list; the first pair of a candidate seeds it
  assign mn_new = (tag.occ_first || (dist_sq < mn)) ? dist_sq : mn;

  always_ff @(posedge clk) begin
    if (rst) begin
      mn_valid <= 1'b0;
    end else begin
      mn_valid <= dist_valid && tag.occ_last;
    end
    if (dist_valid) begin
      mn     <= mn_new;
      mn_tag <= tag;
    end
  end

  // maximum over candidates; strict compare keeps the earliest on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= mn_valid && mn_tag.cand_last;
      if (start) begin
        found <= 1'b0;
      end else if (mn_valid && (!found || (mn > best))) begin
        found <= 1'b1;
      end
    end
    if (mn_valid && (!found || (mn > best))) begin
      best     <= mn;
      best_idx <= mn_tag.cand_idx;
    end
  end

endmodule

`default_nettype wire

[rtl/maximin_spawn_point_select_unit.sv]
// Maximin spawn point select, top level: command decode, point stores, sequencer.
// Depends on mssu_pkg, mssu_point_ram, mssu_dist_unit and mssu_maximin.
//
// Clear and add commands take one beat each and give no result.
// A select walks every candidate/occupied pair through one shared squarer that
// handles one axis per cycle, taking X, Y and Z of each pair in turn; when either
// list is empty the result is offered without walking any pair. No new beat is
// taken while a select runs. The lists and the overflow flag are emptied as the
// select is taken. Point stores have no reset: only loaded entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module maximin_spawn_point_select_unit #(
  parameter int MAX_CANDIDATES = 16,
  parameter int MAX_OCCUPIED   = 64,
  parameter int COORD_BITS     = 21
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [mssu_pkg::CMD_W-1:0]             command,
  input  logic signed [mssu_pkg::POS_W-1:0]      pos_x,
  input  logic signed [mssu_pkg::POS_W-1:0]      pos_y,
  input  logic signed [mssu_pkg::POS_W-1:0]      pos_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   found,
  output logic [mssu_pkg::IDX_W-1:0]             chosen_index,
  output logic [mssu_pkg::DIST_W-1:0]            best_min_dist_sq,
  output logic                                   load_overflow
);
  import mssu_pkg::*;

  localparam int CAW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CCW = $clog2(MAX_CANDIDATES + 1);
  localparam int OAW = (MAX_OCCUPIED > 1) ? $clog2(MAX_OCCUPIED) : 1;
  localparam int OCW = $clog2(MAX_OCCUPIED + 1);
  localparam int PW  = 3 * COORD_BITS;
  localparam int DSW = 2 * COORD_BITS + 2;
  localparam int XW  = (CAW > IDX_W) ? CAW : IDX_W;

  state_t         state;
  state_t         state_next;
  cmd_t           cmd;
  logic           in_acc;
  logic           start_sel;
  logic           cand_full;
  logic           occ_full;
  logic           cand_we;
  logic           occ_we;
  logic [CCW-1:0] cand_count;
  logic [OCW-1:0] occ_count;
  logic [CCW-1:0] cand_top;
  logic [OCW-1:0] occ_top;
  logic           overflow_seen;
  logic           ovf_hold;
  logic [CAW-1:0] c_idx;
  logic [CAW-1:0] c_idx_next;
  logic [CAW-1:0] c_last;
  logic [OAW-1:0] o_idx;
  logic [OAW-1:0] o_idx_next;
  logic [OAW-1:0] o_last;
  logic [XW-1:0]  c_idx_ext;
  ph_t            ph;
  ph_t            ph_next;
  logic           rd_en;
  logic           issue;
  logic           out_load;
  logic           pair_last;
  logic [PW-1:0]  pt_wdata;
  logic [PW-1:0]  cand_pt;
  logic [PW-1:0]  occ_pt;
  pair_tag_t      tag;
  pair_tag_t      dist_tag;
  logic           dist_valid;
  logic [DSW-1:0] dist_sq;
  logic           mm_found;
  logic [IDX_W-1:0] mm_idx;
  logic [DSW-1:0] mm_best;
  logic           mm_done;

  // command decode
  assign cmd       = cmd_t'(command);
  assign in_acc    = in_valid && in_ready;
  assign start_sel = in_acc && (cmd == CMD_SELECT);
  assign cand_full = (cand_count == CCW'(MAX_CANDIDATES));
  assign occ_full  = (occ_count == OCW'(MAX_OCCUPIED));
  assign cand_we   = in_acc && (cmd == CMD_ADD_CAND) && !cand_full;
  assign occ_we    = in_acc && (cmd == CMD_ADD_OCC) && !occ_full;
  assign cand_top  = cand_count - CCW'(1);
  assign occ_top   = occ_count - OCW'(1);
  assign pt_wdata  = {pos_z[COORD_BITS-1:0], pos_y[COORD_BITS-1:0], pos_x[COORD_BITS-1:0]};

  // list fill counts and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_count    <= '0;
      occ_count     <= '0;
      overflow_seen <= 1'b0;
    end else if (in_acc) begin
      case (cmd)
        CMD_ADD_CAND: begin
          if (cand_full) overflow_seen <= 1'b1;
          else           cand_count    <= cand_count + CCW'(1);
        end
        CMD_ADD_OCC: begin
          if (occ_full) overflow_seen <= 1'b1;
          else          occ_count     <= occ_count + OCW'(1);
        end
        default: begin
          cand_count    <= '0;
          occ_count     <= '0;
          overflow_seen <= 1'b0;
        end
      endcase
    end
  end

  // snapshot of the lists taken with the select beat
  always_ff @(posedge clk) begin
    if (start_sel) begin
      ovf_hold <= overflow_seen;
      c_last   <= cand_top[CAW-1:0];
      o_last   <= occ_top[OAW-1:0];
    end
  end

  // point stores
  mssu_point_ram #(
    .DEPTH  (MAX_CANDIDATES),
    .ADDR_W (CAW),
    .WIDTH  (PW)
  ) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (cand_count[CAW-1:0]),
    .wdata (pt_wdata),
    .re    (rd_en),
    .raddr (c_idx_next),
    .rdata (cand_pt)
  );

  mssu_point_ram #(
    .DEPTH  (MAX_OCCUPIED),
    .ADDR_W (OAW),
    .WIDTH  (PW)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_count[OAW-1:0]),
    .wdata (pt_wdata),
    .re    (rd_en),
    .raddr (o_idx_next),
    .rdata (occ_pt)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      c_idx <= '0;
      o_idx <= '0;
      ph    <= PH_X;
    end else begin
      state <= state_next;
      c_idx <= c_idx_next;
      o_idx <= o_idx_next;
      ph    <= ph_next;
    end
  end

  assign pair_last = (o_idx == o_last) && (c_idx == c_last);

  // sequencer: next state, pair walk, store reads
  always_comb begin
    state_next = state;
    c_idx_next = c_idx;
    o_idx_next = o_idx;
    ph_next    = ph;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (start_sel) begin
          c_idx_next = '0;
          o_idx_next = '0;
          ph_next    = PH_X;
          if ((cand_count != '0) && (occ_count != '0)) state_next = ST_PRIME;
          else                                         state_next = ST_OUT;
        end
      end
      ST_PRIME: begin
        rd_en      = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        issue = 1'b1;
        case (ph)
          PH_X: ph_next = PH_Y;
          PH_Y: ph_next = PH_Z;
          default: begin
            ph_next = PH_X;
            if (pair_last) begin
              state_next = ST_DRAIN;
            end else begin
              rd_en = 1'b1;
              if (o_idx == o_last) begin
                o_idx_next = '0;
                c_idx_next = c_idx + CAW'(1);
              end else begin
                o_idx_next = o_idx + OAW'(1);
              end
            end
          end
        endcase
      end
      ST_DRAIN: begin
        if (mm_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // tag for the pair being issued
  assign c_idx_ext     = XW'(c_idx);
  assign tag.occ_first = (o_idx == '0);
  assign tag.occ_last  = (o_idx == o_last);
  assign tag.cand_last = (c_idx == c_last);
  assign tag.cand_idx  = c_idx_ext[IDX_W-1:0];

  mssu_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .ph         (ph),
    .cand_pt    (cand_pt),
    .occ_pt     (occ_pt),
    .tag_in     (tag),
    .dist_valid (dist_valid),
    .dist_sq    (dist_sq),
    .tag_out    (dist_tag)
  );

  mssu_maximin #(
    .DSW (DSW)
  ) u_maximin (
    .clk        (clk),
    .rst        (rst),
    .start      (start_sel),
    .dist_valid (dist_valid),
    .dist_sq    (dist_sq),
    .tag        (dist_tag),
    .found      (mm_found),
    .best_idx   (mm_idx),
    .best       (mm_best),
    .done       (mm_done)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      found            <= mm_found;
      chosen_index     <= mm_found ? mm_idx : '0;
      best_min_dist_sq <= mm_found ? {{(DIST_W-DSW){1'b0}}, mm_best} : '0;
      load_overflow    <= ovf_hold;
    end
  end

  // a select beat empties both lists and the overflow flag
  a_select_empties: assert property (@(posedge clk) disable iff (rst)
    start_sel |=> (cand_count == '0) && (occ_count == '0) && !overflow_seen)
    else $error("lists not emptied after select");

  // the last candidate leaves the compare pipeline only while draining
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == ST_DRAIN))
    else $error("compare pipeline finished outside drain");

  // a result with nothing found carries zero index and distance
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (chosen_index == '0) && (best_min_dist_sq == '0))
    else $error("empty result carries non-zero fields");

  // pairs are only issued with both stores holding read data for a running select
  a_issue_in_run: assert property (@(posedge clk) disable iff (rst)
    issue |-> (state == ST_RUN) && !in_ready)
    else $error("pair issued outside the run state");

endmodule

`default_nettype wire

[tb/sv/maximin_spawn_point_select_unit_tb.sv]
// Testbench for maximin_spawn_point_select_unit: directed and random load/clear/select beats,
// checked against an in-bench farthest-point predictor. Depends on mssu_pkg and the RTL.
`timescale 1ns / 1ps

module maximin_spawn_point_select_unit_tb;
  import mssu_pkg::*;

  localparam int MAX_CAND    = 16;
  localparam int MAX_OCC     = 64;
  localparam int TOTAL_BEATS = 580;
  localparam int HOLD_CYCLES = 1500;

  localparam logic signed [POS_W-1:0] COORD_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] COORD_MAX = {1'b0, {(POS_W-1){1'b1}}};

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  typedef struct {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] dist_sq;
    logic              overflow;
  } pick_t;

  // Tracks both point lists and the picks still owed by the block
  class pick_scoreboard;
    point_t      cand_pts[$];
    point_t      occ_pts[$];
    bit          lost_load;
    pick_t       picks_due[$];
    int unsigned errors;

    function void drop_lists();
      cand_pts.delete();
      occ_pts.delete();
      lost_load = 1'b0;
    endfunction

    // Apply one accepted input beat; a select queues the expected pick
    function void note_beat(cmd_t op, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z);
      point_t p;
      pick_t  r;
      longint best, mn, d, dx, dy, dz;
      p.x = x;
      p.y = y;
      p.z = z;
      case (op)
        CMD_CLEAR: drop_lists();
        CMD_ADD_CAND: begin
          if (cand_pts.size() < MAX_CAND) cand_pts.push_back(p);
          else lost_load = 1'b1;
        end
        CMD_ADD_OCC: begin
          if (occ_pts.size() < MAX_OCC) occ_pts.push_back(p);
          else lost_load = 1'b1;
        end
        CMD_SELECT: begin
          r.found    = 1'b0;
          r.index    = '0;
          r.dist_sq  = '0;
          r.overflow = lost_load;
          best       = 0;
          if (cand_pts.size() > 0 && occ_pts.size() > 0) begin
            foreach (cand_pts[c]) begin
              mn = 0;
              foreach (occ_pts[o]) begin
                dx = cand_pts[c].x - occ_pts[o].x;
                dy = cand_pts[c].y - occ_pts[o].y;
                dz = cand_pts[c].z - occ_pts[o].z;
                d  = dx * dx + dy * dy + dz * dz;
                if (o == 0 || d < mn) mn = d;
              end
              // strict compare: the earliest candidate keeps a tie
              if (!r.found || mn > best) begin
                r.found = 1'b1;
                r.index = IDX_W'(c);
                best    = mn;
              end
            end
          end
          r.dist_sq = DIST_W'(best);
          picks_due.push_back(r);
          drop_lists();
        end
        default: ;
      endcase
    endfunction

    function void check_pick(logic found, logic [IDX_W-1:0] index, logic [DIST_W-1:0] dist_sq,
                             logic overflow);
      pick_t e;
      if (picks_due.size() == 0) begin
        $error("result beat with no select outstanding");
        errors++;
        return;
      end
      e = picks_due.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (index !== e.index) begin
        $error("chosen_index: expected %0d, got %0d", e.index, index);
        errors++;
      end
      if (dist_sq !== e.dist_sq) begin
        $error("best_min_dist_sq: expected %0d, got %0d", e.dist_sq, dist_sq);
        errors++;
      end
      if (overflow !== e.overflow) begin
        $error("load_overflow: expected %0d, got %0d", e.overflow, overflow);
        errors++;
      end
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         command   = CMD_CLEAR;
  logic signed [POS_W-1:0]  pos_x     = '0;
  logic signed [POS_W-1:0]  pos_y     = '0;
  logic signed [POS_W-1:0]  pos_z     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     found;
  logic [IDX_W-1:0]         chosen_index;
  logic [DIST_W-1:0]        best_min_dist_sq;
  logic                     load_overflow;

  pick_scoreboard sb = new();

  int unsigned send_idle    = 0;
  int unsigned recv_stall   = 0;
  int unsigned holds_asked  = 0;
  int unsigned beats_sent   = 0;

  maximin_spawn_point_select_unit #(
    .MAX_CANDIDATES(MAX_CAND),
    .MAX_OCCUPIED  (MAX_OCC),
    .COORD_BITS    (POS_W)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .chosen_index    (chosen_index),
    .best_min_dist_sq(best_min_dist_sq),
    .load_overflow   (load_overflow)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Result beats
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pick(found, chosen_index, best_min_dist_sq, load_overflow);
  end

  // Coordinate styles: 0 full range, 1 tight cluster (ties), 2 extremes
  function automatic logic signed [POS_W-1:0] pick_coord(int unsigned style);
    int v;
    case (style)
      1: begin
        v = int'($urandom_range(6)) - 3;
        return POS_W'(v);
      end
      2: begin
        case ($urandom_range(4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return '1;
          default: return POS_W'(1);
        endcase
      end
      default: return POS_W'($urandom);
    endcase
  endfunction

  // Offer one beat, optionally after an idle gap, and hold it until taken
  task automatic send_beat(cmd_t op, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                           logic signed [POS_W-1:0] z);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    command  <= op;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(op, x, y, z);
    beats_sent++;
  endtask

  // Load both lists in random interleave, then close with a select or a clear
  task automatic load_lists(int unsigned n_cand, int unsigned n_occ, int unsigned style,
                            cmd_t closing);
    int unsigned left_c, left_o;
    left_c = n_cand;
    left_o = n_occ;
    while (left_c + left_o > 0) begin
      if (left_o == 0 || (left_c > 0 && $urandom_range(1) == 1)) begin
        send_beat(CMD_ADD_CAND, pick_coord(style), pick_coord(style), pick_coord(style));
        left_c--;
      end else begin
        send_beat(CMD_ADD_OCC, pick_coord(style), pick_coord(style), pick_coord(style));
        left_o--;
      end
    end
    send_beat(closing, pick_coord(0), pick_coord(0), pick_coord(0));
  endtask

  // Stimulus
  initial begin
    int unsigned phase, r, n_cand, n_occ;
    bit pressed;
    pressed = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty select
    send_beat(CMD_SELECT, COORD_MAX, COORD_MIN, '1);
    // opposite corners give the largest distance
    send_beat(CMD_ADD_CAND, COORD_MIN, COORD_MIN, COORD_MIN);
    send_beat(CMD_ADD_OCC, COORD_MAX, COORD_MAX, COORD_MAX);
    send_beat(CMD_SELECT, '0, '0, '0);
    // tie between the second and third candidate: the second wins
    send_beat(CMD_ADD_OCC, '0, '0, '0);
    send_beat(CMD_ADD_CAND, 21'sd1, 21'sd1, 21'sd1);
    send_beat(CMD_ADD_CAND, '0, 21'sd3, '0);
    send_beat(CMD_ADD_CAND, -21'sd3, '0, '0);
    send_beat(CMD_SELECT, COORD_MIN, COORD_MAX, '0);
    // candidates only, then occupied only
    send_beat(CMD_ADD_CAND, 21'sd5, -21'sd7, 21'sd9);
    send_beat(CMD_SELECT, '0, '0, '0);
    send_beat(CMD_ADD_OCC, -21'sd5, 21'sd7, -21'sd9);
    send_beat(CMD_SELECT, '0, '0, '0);
    // clear throws loaded points away
    send_beat(CMD_ADD_CAND, COORD_MAX, '0, COORD_MIN);
    send_beat(CMD_ADD_OCC, '0, COORD_MAX, '0);
    send_beat(CMD_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX);
    send_beat(CMD_SELECT, '0, '0, '0);

    // Both lists past full, and a full candidate list with no occupied points
    load_lists(MAX_CAND + 1, MAX_OCC + 1, 0, CMD_SELECT);
    load_lists(MAX_CAND + 1, 0, 2, CMD_SELECT);

    // Random sequences over four idling phases
    while (beats_sent < TOTAL_BEATS) begin
      phase = beats_sent * 4 / TOTAL_BEATS;
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 68; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 68; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase

      // long receiver hold-off so the input backs up behind a waiting result
      if (!pressed && phase == 0) begin
        pressed = 1'b1;
        holds_asked++;
      end

      r = $urandom_range(99);
      n_cand = ($urandom_range(99) < 8) ? 0 :
               ($urandom_range(99) < 5) ? $urandom_range(MAX_CAND + 1, MAX_CAND) :
               $urandom_range(6, 1);
      n_occ  = ($urandom_range(99) < 8) ? 0 :
               ($urandom_range(99) < 3 && n_cand <= 3) ? $urandom_range(MAX_OCC + 2, MAX_OCC - 2) :
               $urandom_range(8, 1);
      if (r < 6)
        send_beat(CMD_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0));
      else if (r < 14)
        load_lists(n_cand, n_occ, $urandom_range(2), CMD_CLEAR);
      else
        load_lists(n_cand, n_occ, $urandom_range(2), CMD_SELECT);
    end
    in_valid <= 1'b0;

    // Drain, then wait for any stray result
    while (sb.picks_due.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0)
      $display("[maximin_spawn_point_select_unit] OK");
    else
      $display("[maximin_spawn_point_select_unit] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("[maximin_spawn_point_select_unit] ERROR");
    $finish;
  end

endmodule
